// ----- hw/rtl/vnf_pkg.sv -----
package vnf_pkg;

   localparam int unsigned HashPoints = 16;
   localparam logic [31:0] HashRowMul = 32'd57;
   localparam logic [31:0] HashMulA = 32'd15731;
   localparam logic [31:0] HashAddA = 32'd789221;
   localparam logic [31:0] HashAddB = 32'd1376312589;
   localparam longint unsigned PiQ30 = 64'd3373259426;
   localparam logic signed [35:0] SumMax = 36'sd2147483647;
   localparam logic signed [35:0] SumMin = -36'sd2147483648;

   typedef enum logic [1:0] {
      CSR_BASE_FREQ  = 2'd0,
      CSR_START_AMP  = 2'd1,
      CSR_PERSIST    = 2'd2,
      CSR_OCT_COUNT  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CELL,
      ST_HASH,
      ST_SMOOTH,
      ST_BLEND,
      ST_SCALE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [23:0] base_frequency;
      logic [23:0] start_amplitude;
      logic [15:0] persistence;
      logic [3:0]  octave_count;
   } cfg_type;

   typedef struct packed {
      logic [11:0] x_coord;
      logic [11:0] y_coord;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic [3:0]  idx;
      logic [31:0] cx;
      logic [31:0] cy;
   } hash_req_type;

   typedef struct packed {
      logic        valid;
      logic [3:0]  idx;
      logic [30:0] m;
   } hash_rsp_type;

   // 65536*(1-cos(pi*i/T))/2 from a truncated Taylor series in Q30
   function automatic logic [16:0] cos_w(input int unsigned idx, input int unsigned bits);
      longint unsigned b;
      longint unsigned term;
      longint unsigned sq;
      longint unsigned w;
      longint s;
      b = (PiQ30 * longint'(idx)) >> (bits + 1);
      term = b;
      s = longint'(b);
      for (int k = 1; k <= 7; k++) begin
         term = (term * b) >> 30;
         term = (term * b) >> 30;
         case (k)
            1: term = term / 6;
            2: term = term / 20;
            3: term = term / 42;
            4: term = term / 72;
            5: term = term / 110;
            6: term = term / 156;
            default: term = term / 210;
         endcase
         if ((k % 2) == 1) s = s - longint'(term);
         else s = s + longint'(term);
      end
      if (s < 0) s = 0;
      sq = longint'(s) * longint'(s);
      w = (sq + (64'd1 << 43)) >> 44;
      if (w > 65536) w = 65536;
      return w[16:0];
   endfunction

endpackage

// ----- hw/rtl/vnf_front.sv -----
module vnf_front
   import vnf_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_x_coord,
   input  logic [11:0] req_y_coord,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   localparam logic [11:0] CoordMask = 12'((64'd1 << COORD_BITS) - 64'd1);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_stall = (count_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign pop = q_pop && q_valid;
   assign q_valid = (count_ff != 2'd0);
   assign q_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // coordinates outside the configured range are folded here
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].x_coord <= req_x_coord & CoordMask;
         slot_ff[wr_ptr_ff].y_coord <= req_y_coord & CoordMask;
      end
   end

endmodule

// ----- hw/rtl/vnf_hash.sv -----
module vnf_hash
   import vnf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  hash_req_type req,
   output hash_rsp_type rsp
);

   logic [3:0]  valid_ff;
   logic [3:0]  idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [31:0] n1_ff, n2_ff, n3_ff;
   logic [31:0] sq_ff, t_ff;
   logic [30:0] m_ff;
   logic [31:0] n0, n1_in, u;

   always_comb begin
      n0 = req.cx + req.cy * HashRowMul;
      n1_in = (n0 << 13) ^ n0;
      u = n3_ff * t_ff + HashAddB;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 4'd0;
      else valid_ff <= {valid_ff[2:0], req.valid};
   end

   always_ff @(posedge clock) begin
      n1_ff <= n1_in;
      idx1_ff <= req.idx;
      sq_ff <= n1_ff * n1_ff;
      n2_ff <= n1_ff;
      idx2_ff <= idx1_ff;
      t_ff <= sq_ff * HashMulA + HashAddA;
      n3_ff <= n2_ff;
      idx3_ff <= idx2_ff;
      m_ff <= u[30:0];
      idx4_ff <= idx3_ff;
   end

   assign rsp.valid = valid_ff[3];
   assign rsp.idx = idx4_ff;
   assign rsp.m = m_ff;

endmodule

// ----- hw/rtl/vnf_back.sv -----
module vnf_back
   import vnf_pkg::*;
#(
   parameter int MAX_OCTAVES = 8,
   parameter int COS_TABLE_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                q_valid,
   input  item_type            q_item,
   output logic                q_pop,
   output hash_req_type        hash_req,
   input  hash_rsp_type        hash_rsp,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_noise_value,
   output logic                rsp_saturated
);

   localparam int OctW = $clog2(MAX_OCTAVES + 1);
   localparam int TabSize = 1 << COS_TABLE_BITS;

   logic [16:0] cos_tab [TabSize];
   for (genvar i = 0; i < TabSize; i++) begin : g_cos
      localparam logic [16:0] W = cos_w(i, COS_TABLE_BITS);
      assign cos_tab[i] = W;
   end

   state_type state_ff, state_in;

   logic [35:0]         px_prod_ff, px_prod_in;
   logic [35:0]         py_prod_ff, py_prod_in;
   logic [OctW-1:0]     count_ff, count_in;
   logic [OctW-1:0]     oct_ff, oct_in;
   logic [23:0]         amp_ff, amp_in;
   logic signed [35:0]  sum_ff, sum_in;
   logic [31:0]         cx_ff, cx_in, cy_ff, cy_in;
   logic [15:0]         fx_ff, fx_in, fy_ff, fy_in;
   logic [4:0]          iss_ff, iss_in;
   logic [4:0]          rcv_ff, rcv_in;
   logic [30:0]         h_ff [HashPoints];
   logic signed [17:0]  sm_ff [4];
   logic [1:0]          bcnt_ff, bcnt_in;
   logic signed [17:0]  top_ff, bot_ff, val_ff;
   logic                out_valid_ff;
   logic signed [31:0]  out_value_ff;
   logic                out_sat_ff;

   logic                out_free;
   logic [OctW-1:0]     count_clamped;
   logic [63:0]         sx_shift, sy_shift;
   logic signed [17:0]  sm_new [4];
   logic signed [17:0]  ba, bb, bres;
   logic [15:0]         bfrac;
   logic [16:0]         bw;
   logic signed [18:0]  bdiff;
   logic signed [36:0]  bprod;
   logic signed [42:0]  scale_prod;
   logic [39:0]         amp_prod;
   logic signed [31:0]  fin_value;
   logic                fin_sat;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign count_clamped = (5'(cfg.octave_count) > 5'(MAX_OCTAVES)) ?
                          OctW'(MAX_OCTAVES) : OctW'(cfg.octave_count);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (q_valid) state_in = ST_LOAD;
         ST_LOAD:   state_in = (count_clamped == '0) ? ST_DONE : ST_CELL;
         ST_CELL:   state_in = ST_HASH;
         ST_HASH:   if (rcv_ff == 5'(HashPoints)) state_in = ST_SMOOTH;
         ST_SMOOTH: state_in = ST_BLEND;
         ST_BLEND:  if (bcnt_ff == 2'd2) state_in = ST_SCALE;
         ST_SCALE:  state_in = (oct_ff + 1'b1 == count_ff) ? ST_DONE : ST_CELL;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // smoothing over the 4x4 grid of hashes: corner (ox,oy) centres on (ox+1,oy+1)
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         logic signed [36:0] acc;
         acc = '0;
         for (int r = 0; r < 3; r++) begin
            for (int q = 0; q < 3; q++) begin
               logic signed [36:0] hv;
               hv = 37'sd1073741824 - $signed({6'd0, h_ff[((c / 2) + r) * 4 + (c % 2) + q]});
               if (r == 1 && q == 1) acc = acc + (hv <<< 2);
               else if (r == 1 || q == 1) acc = acc + (hv <<< 1);
               else acc = acc + hv;
            end
         end
         sm_new[c] = 18'(acc >>> 18);
      end
   end

   // blend step: top, bottom, then vertical
   always_comb begin
      case (bcnt_ff)
         2'd0: begin ba = sm_ff[0]; bb = sm_ff[1]; bfrac = fx_ff; end
         2'd1: begin ba = sm_ff[2]; bb = sm_ff[3]; bfrac = fx_ff; end
         default: begin ba = top_ff; bb = bot_ff; bfrac = fy_ff; end
      endcase
      bw = cos_tab[bfrac[15 -: COS_TABLE_BITS]];
      bdiff = 19'(bb) - 19'(ba);
      bprod = bdiff * $signed({1'b0, bw});
      bres = 18'(37'(ba) + (bprod >>> 16));
   end

   always_comb begin
      sx_shift = {28'd0, px_prod_ff} << oct_ff;
      sy_shift = {28'd0, py_prod_ff} << oct_ff;
      scale_prod = val_ff * $signed({1'b0, amp_ff});
      amp_prod = amp_ff * cfg.persistence;
      if (sum_ff > SumMax) begin
         fin_value = 32'sh7FFFFFFF;
         fin_sat = 1'b1;
      end else if (sum_ff < SumMin) begin
         fin_value = 32'sh80000000;
         fin_sat = 1'b1;
      end else begin
         fin_value = 32'(sum_ff);
         fin_sat = 1'b0;
      end
   end

   // datapath and outputs
   always_comb begin
      px_prod_in = px_prod_ff;
      py_prod_in = py_prod_ff;
      count_in = count_ff;
      oct_in = oct_ff;
      amp_in = amp_ff;
      sum_in = sum_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      fx_in = fx_ff;
      fy_in = fy_ff;
      iss_in = iss_ff;
      rcv_in = rcv_ff;
      bcnt_in = bcnt_ff;
      q_pop = 1'b0;
      hash_req.valid = 1'b0;
      hash_req.idx = iss_ff[3:0];
      hash_req.cx = cx_ff + 32'(iss_ff[1:0]) - 32'd1;
      hash_req.cy = cy_ff + 32'(iss_ff[3:2]) - 32'd1;
      case (state_ff)
         ST_LOAD: begin
            q_pop = 1'b1;
            px_prod_in = q_item.x_coord * cfg.base_frequency;
            py_prod_in = q_item.y_coord * cfg.base_frequency;
            count_in = count_clamped;
            oct_in = '0;
            amp_in = cfg.start_amplitude;
            sum_in = '0;
         end
         ST_CELL: begin
            cx_in = sx_shift[47:16];
            cy_in = sy_shift[47:16];
            fx_in = sx_shift[15:0];
            fy_in = sy_shift[15:0];
            iss_in = '0;
            rcv_in = '0;
         end
         ST_HASH: begin
            if (iss_ff != 5'(HashPoints)) begin
               hash_req.valid = 1'b1;
               iss_in = iss_ff + 5'd1;
            end
            if (hash_rsp.valid) rcv_in = rcv_ff + 5'd1;
            bcnt_in = '0;
         end
         ST_BLEND: begin
            bcnt_in = bcnt_ff + 2'd1;
         end
         ST_SCALE: begin
            // val_ff holds this octave's blend here
            sum_in = sum_ff + 36'(scale_prod >>> 16);
            amp_in = amp_prod[39:16];
            oct_in = oct_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && out_free) out_valid_ff <= 1'b1;
         else if (!rsp_stall) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      px_prod_ff <= px_prod_in;
      py_prod_ff <= py_prod_in;
      count_ff <= count_in;
      oct_ff <= oct_in;
      amp_ff <= amp_in;
      sum_ff <= sum_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      fx_ff <= fx_in;
      fy_ff <= fy_in;
      iss_ff <= iss_in;
      rcv_ff <= rcv_in;
      bcnt_ff <= bcnt_in;
      if (hash_rsp.valid) h_ff[hash_rsp.idx] <= hash_rsp.m;
      if (state_ff == ST_SMOOTH) begin
         for (int c = 0; c < 4; c++) sm_ff[c] <= sm_new[c];
      end
      if (state_ff == ST_BLEND) begin
         case (bcnt_ff)
            2'd0: top_ff <= bres;
            2'd1: bot_ff <= bres;
            default: val_ff <= bres;
         endcase
      end
      if (state_ff == ST_DONE && out_free) begin
         out_value_ff <= fin_value;
         out_sat_ff <= fin_sat;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_noise_value = out_value_ff;
   assign rsp_saturated = out_sat_ff;

endmodule

// ----- hw/rtl/value_noise_fbm_sample.sv -----
// Each octave does a cell split, issues the sixteen lattice hashes into the hash
// pipeline and waits for them to drain, then does smoothing, three cosine blends
// and scaling.
// Words are processed one at a time: the sequencer takes the next queued word
// only once the current result word has been loaded into the output register.
// A two-word input queue and an output register decouple both sides.
// Reset (synchronous, active high) empties the queue, idles the sequencer and
// restores the configuration defaults.
module value_noise_fbm_sample
   import vnf_pkg::*;
#(
   parameter int MAX_OCTAVES = 8,
   parameter int COS_TABLE_BITS = 8,
   parameter int COORD_BITS = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [11:0]        req_x_coord,
   input  logic [11:0]        req_y_coord,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_noise_value,
   output logic               rsp_saturated,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   cfg_type      cfg_ff;
   logic         q_valid;
   item_type     q_item;
   logic         q_pop;
   hash_req_type hash_req;
   hash_rsp_type hash_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_frequency <= 24'd65536;
         cfg_ff.start_amplitude <= 24'd65536;
         cfg_ff.persistence <= 16'd32768;
         cfg_ff.octave_count <= 4'd4;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE_FREQ: cfg_ff.base_frequency <= csr_wdata;
            CSR_START_AMP: cfg_ff.start_amplitude <= csr_wdata;
            CSR_PERSIST:   cfg_ff.persistence <= csr_wdata[15:0];
            CSR_OCT_COUNT: cfg_ff.octave_count <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   vnf_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_x_coord (req_x_coord),
      .req_y_coord (req_y_coord),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   vnf_hash u_hash (
      .clock (clock),
      .reset (reset),
      .req   (hash_req),
      .rsp   (hash_rsp)
   );

   vnf_back #(
      .MAX_OCTAVES    (MAX_OCTAVES),
      .COS_TABLE_BITS (COS_TABLE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .hash_req        (hash_req),
      .hash_rsp        (hash_rsp),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_noise_value (rsp_noise_value),
      .rsp_saturated   (rsp_saturated)
   );

endmodule

// ----- hw/rtl/vnf_checker.sv -----
module vnf_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_noise_value,
   input logic               rsp_saturated
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   a_sat_limits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
      (rsp_noise_value == 32'sh7FFFFFFF || rsp_noise_value == 32'sh80000000))
      else $error("clipped word not at a limit");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(rsp_noise_value) && $stable(rsp_saturated)))
      else $error("stalled result word changed");

endmodule

bind value_noise_fbm_sample vnf_checker u_vnf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_noise_value (rsp_noise_value),
   .rsp_saturated   (rsp_saturated)
);

// ----- bench/tb_top.sv -----
module tb_top;
   import vnf_pkg::*;

   localparam int NumOct = 8;
   localparam int CosBits = 8;
   localparam int DrainCycles = 320;

   typedef struct {
      logic [11:0] x;
      logic [11:0] y;
   } coord_type;

   typedef struct {
      logic signed [31:0] noise;
      logic               sat;
   } sample_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [11:0]        req_x_coord;
   logic [11:0]        req_y_coord;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_noise_value;
   logic               rsp_saturated;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [23:0]        csr_wdata;

   coord_type   pending_coords[$];
   sample_type  expected_samples[$];
   longint      cos_weights[0:(1 << CosBits) - 1];
   logic [23:0] freq_reg;
   logic [23:0] amp_reg;
   logic [15:0] persist_reg;
   logic [3:0]  octaves_reg;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          mismatches;
   int          hold_left;
   bit          hold_pending;

   value_noise_fbm_sample dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic longint hash_point(logic [31:0] cx, logic [31:0] cy);
      logic [31:0] n;
      logic [31:0] m;
      n = cx + cy * HashRowMul;
      n = (n << 13) ^ n;
      m = (n * (n * n * HashMulA + HashAddA) + HashAddB) & 32'h7fff_ffff;
      return 64'sh4000_0000 - longint'(m);
   endfunction

   function automatic longint smoothed_corner(logic [31:0] cx, logic [31:0] cy);
      longint acc;
      acc = 4 * hash_point(cx, cy)
          + 2 * (hash_point(cx - 1, cy) + hash_point(cx + 1, cy)
               + hash_point(cx, cy - 1) + hash_point(cx, cy + 1))
          + hash_point(cx - 1, cy - 1) + hash_point(cx + 1, cy - 1)
          + hash_point(cx - 1, cy + 1) + hash_point(cx + 1, cy + 1);
      return acc >>> 18;
   endfunction

   // Taylor series of sin, squared: 65536*(1-cos)/2
   function automatic longint cos_entry(int unsigned i);
      longint unsigned ang;
      longint unsigned t;
      longint          s;
      longint unsigned w;
      ang = (PiQ30 * longint'(i)) >> (CosBits + 1);
      t = ang;
      s = longint'(ang);
      for (int k = 1; k <= 7; k++) begin
         t = (t * ang) >> 30;
         t = (t * ang) >> 30;
         t = t / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) s = s - longint'(t);
         else s = s + longint'(t);
      end
      if (s < 0) s = 0;
      w = (longint'(s) * longint'(s) + (64'd1 << 43)) >> 44;
      if (w > 65536) w = 65536;
      return longint'(w);
   endfunction

   function automatic longint cos_blend(longint a, longint b, logic [15:0] frac);
      longint w;
      w = cos_weights[frac >> (16 - CosBits)];
      return (a * (65536 - w) + b * w) >>> 16;
   endfunction

   function automatic sample_type fbm_sample(coord_type c);
      sample_type      r;
      longint unsigned amp;
      longint unsigned sx;
      longint unsigned sy;
      longint          acc;
      longint          top;
      longint          bot;
      longint          val;
      logic [31:0]     cx;
      logic [31:0]     cy;
      int              count;
      count = (octaves_reg > NumOct) ? NumOct : octaves_reg;
      amp = amp_reg;
      acc = 0;
      for (int k = 0; k < count; k++) begin
         sx = longint'(c.x) * (longint'(freq_reg) << k);
         sy = longint'(c.y) * (longint'(freq_reg) << k);
         cx = sx[47:16];
         cy = sy[47:16];
         top = cos_blend(smoothed_corner(cx, cy), smoothed_corner(cx + 1, cy), sx[15:0]);
         bot = cos_blend(smoothed_corner(cx, cy + 1), smoothed_corner(cx + 1, cy + 1),
                         sx[15:0]);
         val = cos_blend(top, bot, sy[15:0]);
         acc = acc + ((val * longint'(amp)) >>> 16);
         amp = (amp * persist_reg) >> 16;
      end
      r.sat = 1'b0;
      if (acc > 64'sd2147483647) begin
         acc = 64'sd2147483647;
         r.sat = 1'b1;
      end else if (acc < -64'sd2147483648) begin
         acc = -64'sd2147483648;
         r.sat = 1'b1;
      end
      r.noise = acc[31:0];
      return r;
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            expected_samples.push_back(fbm_sample('{req_x_coord, req_y_coord}));
         if (pending_coords.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_x_coord <= pending_coords[0].x;
            req_y_coord <= pending_coords[0].y;
            pending_coords.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long hold-off on the result side
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
      else if (hold_pending) begin
         hold_left <= 600;
         hold_pending <= 1'b0;
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      sample_type exp_word;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_noise_value);
         end else begin
            exp_word = expected_samples.pop_front();
            if (exp_word.noise !== rsp_noise_value || exp_word.sat !== rsp_saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0b got %0d/%0b", exp_word.noise,
                           exp_word.sat, rsp_noise_value, rsp_saturated);
            end
         end
      end
      rsp_stall <= (hold_left > 1) || ($urandom_range(99) < recv_stall_pct);
   end

   task automatic write_reg(csr_index_type idx, logic [23:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_BASE_FREQ: freq_reg = value;
         CSR_START_AMP: amp_reg = value;
         CSR_PERSIST:   persist_reg = value[15:0];
         default:       octaves_reg = value[3:0];
      endcase
   endtask

   task automatic set_regs(logic [23:0] f, logic [23:0] a, logic [15:0] p, logic [3:0] o);
      write_reg(CSR_BASE_FREQ, f);
      write_reg(CSR_START_AMP, a);
      write_reg(CSR_PERSIST, {8'd0, p});
      write_reg(CSR_OCT_COUNT, {20'd0, o});
   endtask

   task automatic run_phase(int mode, int count);
      case (mode % 4)
         0: begin send_idle_pct = 0; recv_stall_pct = 0; end
         1: begin send_idle_pct = 56; recv_stall_pct = 0; end
         2: begin send_idle_pct = 0; recv_stall_pct = 56; end
         default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int i = 0; i < count; i++)
         pending_coords.push_back('{12'($urandom), 12'($urandom)});
      while (pending_coords.size() > 0 || req_valid || expected_samples.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < (1 << CosBits); i++) cos_weights[i] = cos_entry(i);
      mismatches = 0;
      hold_left = 0;
      hold_pending = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_x_coord <= '0;
      req_y_coord <= '0;
      rsp_stall <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_BASE_FREQ;
      csr_wdata <= '0;
      freq_reg = 24'd65536;
      amp_reg = 24'd65536;
      persist_reg = 16'd32768;
      octaves_reg = 4'd4;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners of the coordinate space and one interior point at reset settings
      pending_coords.push_back('{12'd0, 12'd0});
      pending_coords.push_back('{12'd4095, 12'd4095});
      pending_coords.push_back('{12'd0, 12'd4095});
      pending_coords.push_back('{12'd4095, 12'd0});
      pending_coords.push_back('{12'd2730, 12'd1365});
      run_phase(0, 5);

      // largest scale: full-scale frequency, amplitude and persistence at eight octaves
      set_regs(24'hff_ffff, 24'hff_ffff, 16'hffff, 4'd8);
      pending_coords.push_back('{12'd4095, 12'd4095});
      pending_coords.push_back('{12'd1, 12'd4094});
      run_phase(1, 10);
      // count above the octave limit is clamped
      set_regs(24'hff_ffff, 24'hff_ffff, 16'd0, 4'd15);
      run_phase(2, 8);
      set_regs(24'd0, 24'd0, 16'd0, 4'd0);
      run_phase(3, 6);
      set_regs(24'd1, 24'd1, 16'd1, 4'd1);
      run_phase(0, 6);
      set_regs(24'h00_8000, 24'h40_0000, 16'hc000, 4'd9);
      run_phase(1, 8);

      set_regs(24'd65536, 24'd65536, 16'd32768, 4'd2);
      hold_pending = 1'b1;
      run_phase(0, 40);

      for (int ph = 0; ph < 12; ph++) begin
         set_regs(24'($urandom), 24'($urandom), 16'($urandom),
                  4'((ph % 5 == 0) ? $urandom_range(15) : $urandom_range(4)));
         run_phase(ph, 110);
      end

      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
